// ===== rtl/core/qrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion rate propagation package
// Shared constants, the arctangent table and the side-band types that travel
// with each word down the pipeline.
// ----------------------------------------------------------------------------
package qrp_pkg;

  // Stage counts of the two iterative chains.
  localparam int unsigned RootSteps   = 32;
  localparam int unsigned CordicSteps = 32;

  // 1/(2*pi) in Q0.64 and the CORDIC gain in Q0.32.
  localparam logic [63:0] InvTwoPiQ64   = 64'h28BE60DB9391054A;
  localparam logic [31:0] CordicGainQ32 = 32'h9B74EDA8;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] AtanTurns [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Quaternion in signed Q2.30.
  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  // Side band carried alongside the arithmetic of every stage.
  typedef struct packed {
    quat_t             q;
    logic              zero;
    logic [2:0]        neg;
    logic [4:0]        k;
    logic [2:0][31:0]  u;
  } side_t;

endpackage

// ===== rtl/core/quaternion_rate_propagation_unit.sv =====
// Throughput: one word per cycle unless the output is held; the square root
// and the CORDIC with its dividers are unrolled into 32 register stages each.
// A held output stalls the whole pipeline; the last stage is the output register.
// Reset clears the stage valid bits only; no output word is pending after reset.
// ----------------------------------------------------------------------------
// Quaternion rate propagation unit
// Propagates a unit quaternion over one time step by the exact exponential of
// a constant body rate, in a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
module quaternion_rate_propagation_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  quat_w_i,
  input  logic signed [31:0]  quat_x_i,
  input  logic signed [31:0]  quat_y_i,
  input  logic signed [31:0]  quat_z_i,
  input  logic signed [31:0]  rate_x_i,
  input  logic signed [31:0]  rate_y_i,
  input  logic signed [31:0]  rate_z_i,
  input  logic [31:0]         step_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_w_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o
);
  import qrp_pkg::*;

  // The pipeline moves whenever the output register is free or being taken.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  quat_t quat_in;
  assign quat_in.w = quat_w_i;
  assign quat_in.x = quat_x_i;
  assign quat_in.y = quat_y_i;
  assign quat_in.z = quat_z_i;

  logic        norm_valid;
  side_t       norm_side;
  logic [31:0] norm_root;
  logic [31:0] norm_dt;

  qrp_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .quat_i      (quat_in),
    .rate_x_i    (rate_x_i),
    .rate_y_i    (rate_y_i),
    .rate_z_i    (rate_z_i),
    .step_time_i (step_time_i),
    .valid_o     (norm_valid),
    .side_o      (norm_side),
    .root_o      (norm_root),
    .dt_o        (norm_dt)
  );

  logic        ph_valid;
  side_t       ph_side;
  logic [31:0] ph_root;
  logic [31:0] ph_phase;

  qrp_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .side_i  (norm_side),
    .root_i  (norm_root),
    .dt_i    (norm_dt),
    .valid_o (ph_valid),
    .side_o  (ph_side),
    .root_o  (ph_root),
    .phase_o (ph_phase)
  );

  logic               tr_valid;
  side_t              tr_side;
  logic signed [35:0] tr_x;
  logic signed [35:0] tr_y;
  logic [1:0]         tr_quad;
  logic               tr_rzero;
  logic [2:0][31:0]   tr_e;

  qrp_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .side_i  (ph_side),
    .root_i  (ph_root),
    .phase_i (ph_phase),
    .valid_o (tr_valid),
    .side_o  (tr_side),
    .x_o     (tr_x),
    .y_o     (tr_y),
    .quad_o  (tr_quad),
    .rzero_o (tr_rzero),
    .e_o     (tr_e)
  );

  quat_t quat_out;

  qrp_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_valid),
    .side_i  (tr_side),
    .x_i     (tr_x),
    .y_i     (tr_y),
    .quad_i  (tr_quad),
    .rzero_i (tr_rzero),
    .e_i     (tr_e),
    .valid_o (out_valid_o),
    .quat_o  (quat_out)
  );

  assign out_w_o = quat_out.w;
  assign out_x_o = quat_out.x;
  assign out_y_o = quat_out.y;
  assign out_z_o = quat_out.z;

endmodule

// ===== rtl/core/qrp_norm.sv =====
// ----------------------------------------------------------------------------
// Rate normalisation and magnitude
// Takes absolute rates, scales them to a common exponent, squares and sums
// them and extracts the integer square root one bit per stage.
// ----------------------------------------------------------------------------
module qrp_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qrp_pkg::quat_t      quat_i,
  input  logic signed [31:0]  rate_x_i,
  input  logic signed [31:0]  rate_y_i,
  input  logic signed [31:0]  rate_z_i,
  input  logic [31:0]         step_time_i,
  output logic                valid_o,
  output qrp_pkg::side_t      side_o,
  output logic [31:0]         root_o,
  output logic [31:0]         dt_o
);
  import qrp_pkg::*;

  // Stage A: magnitudes, largest magnitude and scaling exponent.
  logic [2:0][31:0] mag_a;
  logic [31:0]      max_a;
  logic [4:0]       k_a;

  always_comb begin
    mag_a[0] = rate_x_i[31] ? (~rate_x_i + 32'd1) : rate_x_i;
    mag_a[1] = rate_y_i[31] ? (~rate_y_i + 32'd1) : rate_y_i;
    mag_a[2] = rate_z_i[31] ? (~rate_z_i + 32'd1) : rate_z_i;
    max_a = mag_a[0];
    if (mag_a[1] > max_a) max_a = mag_a[1];
    if (mag_a[2] > max_a) max_a = mag_a[2];
    // The exponent lifts the leading one of the largest rate to bit 30.
    k_a = 5'd30;
    for (int b = 0; b < 31; b++) begin
      if (max_a[b]) k_a = 5'(30 - b);
    end
    if (max_a[31]) k_a = 5'd0;
  end

  logic        valid_a_q, valid_b_q, valid_c_q, valid_d_q;
  side_t       side_a_q, side_b_q, side_c_q, side_d_q;
  logic [31:0] dt_a_q, dt_b_q, dt_c_q, dt_d_q;
  logic [2:0][63:0] sq_c_q;
  logic [63:0] sum_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
    end
  end

  // Stages A to D: capture, scale, square, sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q.q    <= quat_i;
      side_a_q.zero <= (rate_x_i == '0) && (rate_y_i == '0) && (rate_z_i == '0);
      side_a_q.neg  <= {rate_z_i[31], rate_y_i[31], rate_x_i[31]};
      side_a_q.k    <= k_a;
      side_a_q.u    <= mag_a;
      dt_a_q        <= step_time_i;

      side_b_q.q    <= side_a_q.q;
      side_b_q.zero <= side_a_q.zero;
      side_b_q.neg  <= side_a_q.neg;
      side_b_q.k    <= side_a_q.k;
      for (int l = 0; l < 3; l++) begin
        side_b_q.u[l] <= side_a_q.u[l] << side_a_q.k;
      end
      dt_b_q        <= dt_a_q;

      side_c_q      <= side_b_q;
      for (int l = 0; l < 3; l++) begin
        sq_c_q[l] <= 64'(side_b_q.u[l]) * 64'(side_b_q.u[l]);
      end
      dt_c_q        <= dt_b_q;

      side_d_q      <= side_c_q;
      sum_d_q       <= sq_c_q[0] + sq_c_q[1] + sq_c_q[2];
      dt_d_q        <= dt_c_q;
    end
  end

  // Square root: one result bit per stage, two radicand bits consumed.
  logic [63:0] rad_w  [RootSteps+1];
  logic [33:0] rem_w  [RootSteps+1];
  logic [31:0] root_w [RootSteps+1];
  logic        vld_w  [RootSteps+1];
  side_t       side_w [RootSteps+1];
  logic [31:0] dt_w   [RootSteps+1];

  assign rad_w[0]  = sum_d_q;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign vld_w[0]  = valid_d_q;
  assign side_w[0] = side_d_q;
  assign dt_w[0]   = dt_d_q;

  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    logic [63:0] rad_q;
    logic [33:0] rem_q;
    logic [31:0] root_q;
    logic        vld_q;
    side_t       side_q;
    logic [31:0] dt_q;

    assign cur   = {rem_w[j], rad_w[j][63-2*j -: 2]};
    assign trial = {2'b00, root_w[j], 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q  <= rad_w[j];
        rem_q  <= ge ? diff[33:0] : cur[33:0];
        root_q <= {root_w[j][30:0], ge};
        side_q <= side_w[j];
        dt_q   <= dt_w[j];
      end
    end

    assign rad_w[j+1]  = rad_q;
    assign rem_w[j+1]  = rem_q;
    assign root_w[j+1] = root_q;
    assign vld_w[j+1]  = vld_q;
    assign side_w[j+1] = side_q;
    assign dt_w[j+1]   = dt_q;
  end

  assign valid_o = vld_w[RootSteps];
  assign side_o  = side_w[RootSteps];
  assign root_o  = root_w[RootSteps];
  assign dt_o    = dt_w[RootSteps];

  // A non-zero rate is scaled so that its magnitude is at least 2^30.
  ast_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.zero) |-> (root_o[31:30] != 2'b00))
    else $error("Rate magnitude below the normalised range.");

endmodule

// ===== rtl/core/qrp_phase.sv =====
// ----------------------------------------------------------------------------
// Rotation phase
// Multiplies magnitude by time step and by 1/(2*pi), then removes the
// scaling exponent to leave the half angle in turns, Q0.32, modulo one turn.
// ----------------------------------------------------------------------------
module qrp_phase (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qrp_pkg::side_t  side_i,
  input  logic [31:0]     root_i,
  input  logic [31:0]     dt_i,
  output logic            valid_o,
  output qrp_pkg::side_t  side_o,
  output logic [31:0]     root_o,
  output logic [31:0]     phase_o
);
  import qrp_pkg::*;

  logic [3:0]  valid_q;
  side_t       side_1_q, side_2_q, side_3_q, side_4_q;
  logic [31:0] root_1_q, root_2_q, root_3_q, root_4_q;
  logic [63:0] prod_1_q;
  logic [63:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [63:0] hi_3_q;
  logic [31:0] phase_4_q;
  logic [127:0] full;
  logic [63:0]  shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Full 128-bit product assembled from the four partial products.
  assign full = {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0} + {32'd0, pp10_q, 32'd0}
              + {pp11_q, 64'd0};
  assign shifted = hi_3_q >> (6'd17 + 6'(side_3_q.k));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: magnitude times time step.
      prod_1_q  <= 64'(root_i) * 64'(dt_i);
      side_1_q  <= side_i;
      root_1_q  <= root_i;
      // Stage 2: partial products against 1/(2*pi).
      pp00_q    <= 64'(prod_1_q[31:0])  * 64'(InvTwoPiQ64[31:0]);
      pp01_q    <= 64'(prod_1_q[31:0])  * 64'(InvTwoPiQ64[63:32]);
      pp10_q    <= 64'(prod_1_q[63:32]) * 64'(InvTwoPiQ64[31:0]);
      pp11_q    <= 64'(prod_1_q[63:32]) * 64'(InvTwoPiQ64[63:32]);
      side_2_q  <= side_1_q;
      root_2_q  <= root_1_q;
      // Stage 3: upper half of the sum.
      hi_3_q    <= full[127:64];
      side_3_q  <= side_2_q;
      root_3_q  <= root_2_q;
      // Stage 4: undo the exponent, keep one turn.
      phase_4_q <= shifted[31:0];
      side_4_q  <= side_3_q;
      root_4_q  <= root_3_q;
    end
  end

  assign valid_o = valid_q[3];
  assign side_o  = side_4_q;
  assign root_o  = root_4_q;
  assign phase_o = phase_4_q;

endmodule

// ===== rtl/core/qrp_trig.sv =====
// ----------------------------------------------------------------------------
// Sine, cosine and direction
// A CORDIC rotation stage and three restoring divider stages run in lock
// step, one iteration of each per register stage.
// ----------------------------------------------------------------------------
module qrp_trig (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  qrp_pkg::side_t          side_i,
  input  logic [31:0]             root_i,
  input  logic [31:0]             phase_i,
  output logic                    valid_o,
  output qrp_pkg::side_t          side_o,
  output logic signed [35:0]      x_o,
  output logic signed [35:0]      y_o,
  output logic [1:0]              quad_o,
  output logic                    rzero_o,
  output logic [2:0][31:0]        e_o
);
  import qrp_pkg::*;

  logic signed [35:0] x_w     [CordicSteps+1];
  logic signed [35:0] y_w     [CordicSteps+1];
  logic signed [32:0] z_w     [CordicSteps+1];
  logic [1:0]         quad_w  [CordicSteps+1];
  logic               rzero_w [CordicSteps+1];
  logic [2:0][32:0]   rem_w   [CordicSteps+1];
  logic [2:0][31:0]   quo_w   [CordicSteps+1];
  logic [31:0]        root_w  [CordicSteps+1];
  side_t              side_w  [CordicSteps+1];
  logic               vld_w   [CordicSteps+1];

  assign x_w[0]     = {4'd0, CordicGainQ32};
  assign y_w[0]     = '0;
  assign z_w[0]     = {3'd0, phase_i[29:0]};
  assign quad_w[0]  = phase_i[31:30];
  assign rzero_w[0] = (phase_i[29:0] == '0);
  assign rem_w[0]   = {{1'b0, side_i.u[2]}, {1'b0, side_i.u[1]}, {1'b0, side_i.u[0]}};
  assign quo_w[0]   = '0;
  assign root_w[0]  = root_i;
  assign side_w[0]  = side_i;
  assign vld_w[0]   = valid_i;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [32:0] at;
    logic [2:0][32:0]   rem_d;
    logic [2:0]         ge;
    logic signed [35:0] x_q;
    logic signed [35:0] y_q;
    logic signed [32:0] z_q;
    logic [1:0]         quad_q;
    logic               rzero_q;
    logic [2:0][32:0]   rem_q;
    logic [2:0][31:0]   quo_q;
    logic [31:0]        root_q;
    side_t              side_q;
    logic               vld_q;

    assign dx = y_w[i] >>> i;
    assign dy = x_w[i] >>> i;
    assign at = {1'b0, AtanTurns[i]};

    // Divider lanes: one quotient bit of (u << 31) / N per stage.
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = rem_w[i][l] >= {1'b0, root_w[i]};
        rem_d[l] = ge[l] ? (rem_w[i][l] - {1'b0, root_w[i]}) : rem_w[i][l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // Rotate towards zero residual angle.
        if (!z_w[i][32]) begin
          x_q <= x_w[i] - dx;
          y_q <= y_w[i] + dy;
          z_q <= z_w[i] - at;
        end else begin
          x_q <= x_w[i] + dx;
          y_q <= y_w[i] - dy;
          z_q <= z_w[i] + at;
        end
        for (int l = 0; l < 3; l++) begin
          rem_q[l] <= {rem_d[l][31:0], 1'b0};
          quo_q[l] <= {quo_w[i][l][30:0], ge[l]};
        end
        quad_q  <= quad_w[i];
        rzero_q <= rzero_w[i];
        root_q  <= root_w[i];
        side_q  <= side_w[i];
      end
    end

    assign x_w[i+1]     = x_q;
    assign y_w[i+1]     = y_q;
    assign z_w[i+1]     = z_q;
    assign quad_w[i+1]  = quad_q;
    assign rzero_w[i+1] = rzero_q;
    assign rem_w[i+1]   = rem_q;
    assign quo_w[i+1]   = quo_q;
    assign root_w[i+1]  = root_q;
    assign side_w[i+1]  = side_q;
    assign vld_w[i+1]   = vld_q;
  end

  assign valid_o = vld_w[CordicSteps];
  assign side_o  = side_w[CordicSteps];
  assign x_o     = x_w[CordicSteps];
  assign y_o     = y_w[CordicSteps];
  assign quad_o  = quad_w[CordicSteps];
  assign rzero_o = rzero_w[CordicSteps];
  assign e_o     = quo_w[CordicSteps];

  // Each rate component is at most the magnitude, so the ratio is at most one.
  ast_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.zero) |->
      (e_o[0] <= 32'h80000000 && e_o[1] <= 32'h80000000 && e_o[2] <= 32'h80000000))
    else $error("Direction ratio above one.");

endmodule

// ===== rtl/core/qrp_mix.sv =====
// ----------------------------------------------------------------------------
// Quaternion product
// Finishes cosine and sine, forms the rotation vector, multiplies it into the
// quaternion and rounds and saturates the result to Q2.30; a zero rate keeps the input quaternion.
// ----------------------------------------------------------------------------
module qrp_mix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qrp_pkg::side_t      side_i,
  input  logic signed [35:0]  x_i,
  input  logic signed [35:0]  y_i,
  input  logic [1:0]          quad_i,
  input  logic                rzero_i,
  input  logic [2:0][31:0]    e_i,
  output logic                valid_o,
  output qrp_pkg::quat_t      quat_o
);
  import qrp_pkg::*;

  localparam logic signed [35:0] One30   = 36'sd1073741824;
  localparam logic signed [65:0] Half30  = 66'sd536870912;
  localparam logic signed [65:0] SatHigh = 66'sd2147483647;
  localparam logic signed [65:0] SatLow  = -66'sd2147483648;

  // Round from 2^-32 to 2^-30 units and clamp to plus or minus one.
  function automatic logic signed [31:0] to_q30(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd2) >>> 2;
    if (t > One30) t = One30;
    if (t < -One30) t = -One30;
    return t[31:0];
  endfunction

  function automatic logic signed [65:0] ext(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  function automatic logic signed [31:0] pack_q30(input logic signed [65:0] acc);
    logic signed [65:0] t;
    t = (acc + Half30) >>> 30;
    if (t > SatHigh) t = SatHigh;
    if (t < SatLow) t = SatLow;
    return t[31:0];
  endfunction

  logic [3:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Stage 1: quadrant rotation and rounding of cosine and sine.
  logic signed [35:0] xs, ys, xr, yr;
  logic signed [31:0] c_1_q, s_1_q;
  logic [2:0][31:0]   e_1_q;
  side_t              side_1_q;

  always_comb begin
    xs = rzero_i ? 36'sh100000000 : x_i;
    ys = rzero_i ? 36'sd0 : y_i;
    unique case (quad_i)
      2'd1: begin
        xr = -ys;
        yr = xs;
      end
      2'd2: begin
        xr = -xs;
        yr = -ys;
      end
      2'd3: begin
        xr = ys;
        yr = -xs;
      end
      default: begin
        xr = xs;
        yr = ys;
      end
    endcase
  end

  // Stage 2: rotation vector components.
  logic [30:0]        abs_s;
  logic [2:0][62:0]   mag_p;
  logic signed [31:0] coef_2_q [4];
  side_t              side_2_q;

  always_comb begin
    abs_s = s_1_q[31] ? 31'(-s_1_q) : s_1_q[30:0];
    for (int l = 0; l < 3; l++) begin
      mag_p[l] = 63'(abs_s) * 63'(e_1_q[l]);
    end
  end

  // Stage 3: the sixteen coefficient by component products.
  logic signed [31:0] comp [4];
  logic signed [63:0] prod_3_q [4][4];
  side_t              side_3_q;

  assign comp[0] = side_2_q.q.w;
  assign comp[1] = side_2_q.q.x;
  assign comp[2] = side_2_q.q.y;
  assign comp[3] = side_2_q.q.z;

  // Stage 4: signed sums, rounding, saturation and the zero-rate bypass.
  logic signed [65:0] acc_w, acc_x, acc_y, acc_z;
  quat_t              quat_4_q;

  always_comb begin
    acc_w = ext(prod_3_q[0][0]) - ext(prod_3_q[1][1]) - ext(prod_3_q[2][2])
          - ext(prod_3_q[3][3]);
    acc_x = ext(prod_3_q[0][1]) + ext(prod_3_q[3][2]) - ext(prod_3_q[2][3])
          + ext(prod_3_q[1][0]);
    acc_y = ext(prod_3_q[0][2]) - ext(prod_3_q[3][1]) + ext(prod_3_q[1][3])
          + ext(prod_3_q[2][0]);
    acc_z = ext(prod_3_q[0][3]) + ext(prod_3_q[2][1]) - ext(prod_3_q[1][2])
          + ext(prod_3_q[3][0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_1_q    <= to_q30(xr);
      s_1_q    <= to_q30(yr);
      e_1_q    <= e_i;
      side_1_q <= side_i;

      coef_2_q[0] <= c_1_q;
      for (int l = 0; l < 3; l++) begin
        coef_2_q[l+1] <= (s_1_q[31] != side_1_q.neg[l]) ? -$signed({1'b0, mag_p[l][61:31]})
                                                         : $signed({1'b0, mag_p[l][61:31]});
      end
      side_2_q <= side_1_q;

      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          prod_3_q[a][b] <= 64'(coef_2_q[a]) * 64'(comp[b]);
        end
      end
      side_3_q <= side_2_q;

      if (side_3_q.zero) begin
        quat_4_q <= side_3_q.q;
      end else begin
        quat_4_q.w <= pack_q30(acc_w);
        quat_4_q.x <= pack_q30(acc_x);
        quat_4_q.y <= pack_q30(acc_y);
        quat_4_q.z <= pack_q30(acc_z);
      end
    end
  end

  assign valid_o = valid_q[3];
  assign quat_o  = quat_4_q;

  // Cosine and sine stay within plus or minus one after rounding.
  ast_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (c_1_q <= 32'sd1073741824 && c_1_q >= -32'sd1073741824 &&
                    s_1_q <= 32'sd1073741824 && s_1_q >= -32'sd1073741824))
    else $error("Cosine or sine outside unit range.");

endmodule
